[hw/rtl/multi_channel_edge_interrupt_core_assert.svh]
// Assertion macros used by the checker file.
// Both sample on posedge clk and stay quiet while rst_n is low.
`ifndef MULTI_CHANNEL_EDGE_INTERRUPT_CORE_ASSERT_SVH
`define MULTI_CHANNEL_EDGE_INTERRUPT_CORE_ASSERT_SVH

// Same-cycle implication.
`define MCEI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcei: same-cycle check failed");

// Next-cycle implication.
`define MCEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcei: next-cycle check failed");

`endif

[hw/rtl/mcei_pkg.sv]
package mcei_pkg;

  localparam int CHANNELS_DEF = 32;
  localparam int CH_W         = 5;
  localparam int STAMP_W      = 32;
  localparam int REG_W        = 32;
  localparam int ADDR_W       = 4;
  localparam int MAX_SLOTS    = 2 ** CH_W;

  // in_beat_t.mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_USED   = 2'd1,
    REG_RISE   = 2'd2,
    REG_FALL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic            mode;     // 1: millisecond tick
    logic [CH_W-1:0] channel;
    logic            level;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]    irq_channel;
    logic               edge_rising;
    logic [STAMP_W-1:0] stamp_ms;
  } out_beat_t;

  // register file -> detector
  typedef struct packed {
    logic             enable;
    logic [REG_W-1:0] used_mask;
    logic [REG_W-1:0] rise_mask;
    logic [REG_W-1:0] fall_mask;
    logic             clr_all;      // enable 1 -> 0
    logic [REG_W-1:0] clr_mask;     // used bits that toggled
    logic             restart_time; // enable 0 -> 1
  } ctl_t;

endpackage

[hw/rtl/mcei_ram.sv]
module mcei_ram #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-before-write on an address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/mcei_regs.sv]
module mcei_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcei_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcei_pkg::REG_W-1:0]   pwdata,
  output logic [mcei_pkg::REG_W-1:0]   prdata,
  output logic                         pready,
  output mcei_pkg::ctl_t               ctl
);

  logic                       enable_r, enable_nxt;
  logic [mcei_pkg::REG_W-1:0] used_r, used_nxt;
  logic [mcei_pkg::REG_W-1:0] rise_r, rise_nxt;
  logic [mcei_pkg::REG_W-1:0] fall_r, fall_nxt;
  logic                       wr;
  mcei_pkg::reg_idx_t         idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = mcei_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_comb begin
    enable_nxt = enable_r;
    used_nxt   = used_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    if (wr) begin
      unique case (idx)
        mcei_pkg::REG_ENABLE: enable_nxt = pwdata[0];
        mcei_pkg::REG_USED:   used_nxt   = pwdata;
        mcei_pkg::REG_RISE:   rise_nxt   = pwdata;
        mcei_pkg::REG_FALL:   fall_nxt   = pwdata;
        default:              enable_nxt = enable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      used_r   <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
    end else begin
      enable_r <= enable_nxt;
      used_r   <= used_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      mcei_pkg::REG_ENABLE: prdata = {{(mcei_pkg::REG_W-1){1'b0}}, enable_r};
      mcei_pkg::REG_USED:   prdata = used_r;
      mcei_pkg::REG_RISE:   prdata = rise_r;
      mcei_pkg::REG_FALL:   prdata = fall_r;
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    ctl              = '0;
    ctl.enable       = enable_r;
    ctl.used_mask    = used_r;
    ctl.rise_mask    = rise_r;
    ctl.fall_mask    = fall_r;
    ctl.clr_all      = wr && (idx == mcei_pkg::REG_ENABLE) && enable_r && !pwdata[0];
    ctl.restart_time = wr && (idx == mcei_pkg::REG_ENABLE) && !enable_r && pwdata[0];
    ctl.clr_mask     = (wr && (idx == mcei_pkg::REG_USED)) ? (used_r ^ pwdata) : '0;
  end

endmodule

[hw/rtl/mcei_detect.sv]
module mcei_detect #(
  parameter int CHANNELS = mcei_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mcei_pkg::ctl_t      ctl,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcei_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcei_pkg::out_beat_t out_data
);

  localparam int SLOTS = (CHANNELS < mcei_pkg::MAX_SLOTS) ? CHANNELS : mcei_pkg::MAX_SLOTS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // elapsed time
  logic [mcei_pkg::STAMP_W-1:0] elapsed_r, elapsed_nxt;

  // stage 1: level RAM data is valid here
  logic                         s1_v_r, s1_v_nxt;
  logic [AW-1:0]                s1_addr_r;
  logic [mcei_pkg::CH_W-1:0]    s1_ch_r;
  logic                         s1_lvl_r;
  logic [mcei_pkg::STAMP_W-1:0] s1_stamp_r;
  logic                         s1_rise_en_r;
  logic                         s1_fall_en_r;
  logic                         fwd_r;
  logic                         fwd_lvl_r;

  // per-slot valid bits: a clear slot reads as level 0
  logic [SLOTS-1:0]             vld_r, vld_nxt;

  // output register
  logic                         out_v_r, out_v_nxt;
  mcei_pkg::out_beat_t          out_r;

  logic                         accept, take, in_range, adv;
  logic [AW-1:0]                rd_addr;
  logic                         ram_q;
  logic                         last_lvl, edge_det, fire, wr_en;

  assign accept   = in_valid && in_ready;
  assign in_range = 32'(in_data.channel) < CHANNELS;
  assign rd_addr  = in_data.channel[AW-1:0];
  assign take     = accept && (in_data.mode == mcei_pkg::MODE_SAMPLE) && ctl.enable
                    && in_range && ctl.used_mask[in_data.channel];

  mcei_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_lvl_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_lvl_r),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // stage 1 compare
  assign last_lvl = fwd_r ? fwd_lvl_r : (vld_r[s1_addr_r] & ram_q);
  assign edge_det = s1_v_r && (last_lvl != s1_lvl_r);
  assign fire     = edge_det && (s1_lvl_r ? s1_rise_en_r : s1_fall_en_r);
  assign adv      = !fire || !out_v_r || out_ready;
  assign wr_en    = edge_det && adv;
  assign in_ready = adv;

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (ctl.restart_time) begin
      elapsed_nxt = '0;
    end else if (accept && (in_data.mode == mcei_pkg::MODE_TICK)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
  end

  assign s1_v_nxt = adv ? take : s1_v_r;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.clr_all) begin
      vld_nxt = '0;
    end else begin
      for (int c = 0; c < SLOTS; c++) begin
        if (ctl.clr_mask[c]) begin
          vld_nxt[c] = 1'b0;
        end
      end
    end
    if (wr_en) begin
      vld_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv && fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      s1_v_r    <= 1'b0;
      vld_r     <= '0;
      out_v_r   <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      elapsed_r <= elapsed_nxt;
      s1_v_r    <= s1_v_nxt;
      vld_r     <= vld_nxt;
      out_v_r   <= out_v_nxt;
      if (accept) begin
        // stage 1 writes this slot at the same edge the RAM is read
        fwd_r <= wr_en && (s1_addr_r == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r    <= rd_addr;
      s1_ch_r      <= in_data.channel;
      s1_lvl_r     <= in_data.level;
      s1_stamp_r   <= elapsed_r;
      s1_rise_en_r <= ctl.rise_mask[in_data.channel];
      s1_fall_en_r <= ctl.fall_mask[in_data.channel];
      fwd_lvl_r    <= s1_lvl_r;
    end
    if (adv && fire) begin
      out_r.irq_channel <= s1_ch_r;
      out_r.edge_rising <= s1_lvl_r;
      out_r.stamp_ms    <= s1_stamp_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/multi_channel_edge_interrupt_core.sv]
// Channel   Handshake              Beat contents
// in_       in_valid / in_ready    mode, channel, level (tick or level sample)
// out_      out_valid / out_ready  irq_channel, edge_rising, stamp_ms
// cfg       psel/penable/pready    enable, used, rise and fall masks (APB)
//
// One beat per cycle while out_ is not stalled; a sample's interrupt beat passes
// the level RAM read into stage 1, then the compare into the out register.
// The last-level RAM has one read and one write port: each accepted beat reads
// its slot, and stage 1 writes back its level when it changed, forwarding same-slot pairs.
// Reset (rst_n, sync, active low) clears config, time and all valid bits.
// in_ready drops only while stage 1 holds an interrupt and out_ is stalled.
module multi_channel_edge_interrupt_core #(
  parameter int CHANNELS = mcei_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample / tick beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mcei_pkg::in_beat_t           in_data,
  // interrupt beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output mcei_pkg::out_beat_t          out_data,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcei_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcei_pkg::REG_W-1:0]   pwdata,
  output logic [mcei_pkg::REG_W-1:0]   prdata,
  output logic                         pready
);

  mcei_pkg::ctl_t ctl;

  // Config registers; enable/used writes also pulse the clear/restart events.
  mcei_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  // Time counter, last-level RAM read-modify-write and output register.
  mcei_detect #(
    .CHANNELS (CHANNELS)
  ) u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/mcei_checker.sv]
`include "multi_channel_edge_interrupt_core_assert.svh"

module mcei_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mcei_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mcei_pkg::out_beat_t out_data
);

  logic                      sample_acc;
  logic [mcei_pkg::CH_W-1:0] irq_ch;
  logic                      irq_rise;

  assign sample_acc = in_valid && in_ready && (in_data.mode == mcei_pkg::MODE_SAMPLE);
  assign irq_ch     = out_data.irq_channel;
  assign irq_rise   = out_data.edge_rising;

  // stalled interrupt beat holds
  `MCEI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a fresh interrupt comes from a sample taken through stage 1 into the out register
  `MCEI_ASSERT_NOW(a_rose_from_sample, $rose(out_valid), $past(sample_acc, 2))

  // and carries that sample's channel and level
  `MCEI_ASSERT_NOW(a_rose_channel, $rose(out_valid), irq_ch == $past(in_data.channel, 2))
  `MCEI_ASSERT_NOW(a_rose_level, $rose(out_valid), irq_rise == $past(in_data.level, 2))

endmodule

bind multi_channel_edge_interrupt_core mcei_checker u_mcei_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/multi_channel_edge_interrupt_core_tb.sv]
`timescale 1ns / 100ps

module multi_channel_edge_interrupt_core_tb;

  localparam int NCH            = mcei_pkg::CHANNELS_DEF;
  localparam int PIPE_CYCLES    = 4;     // RAM read + compare, with margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake of any kind
  localparam int SEGS           = 4;     // register settings per idling phase
  localparam int SEG_BEATS      = 24;

  // Idling phases: none, sender idle, receiver stall, both lightly
  localparam int unsigned TX_IDLE  [4] = '{0, 64, 0, 8};
  localparam int unsigned RX_STALL [4] = '{0, 0, 64, 8};

  // Stimulus table rows: a register write, or a beat whose interrupt is
  // either typed in by hand, known to be absent, or left to the predictor.
  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_IRQ, CHK_QUIET} row_chk_t;

  typedef struct packed {
    row_kind_t           kind;
    mcei_pkg::reg_idx_t  idx;
    logic [31:0]         val;
    mcei_pkg::in_beat_t  beat;
    row_chk_t            chk;
    mcei_pkg::out_beat_t irq;
  } plan_row_t;

  logic                as_clk_unused_dummy_guard;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mcei_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mcei_pkg::out_beat_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [mcei_pkg::ADDR_W-1:0] paddr = '0;
  logic [mcei_pkg::REG_W-1:0]  pwdata = '0;
  logic [mcei_pkg::REG_W-1:0]  prdata;
  logic                pready;

  // How the beat currently on in_data is to be checked; travels with it
  row_chk_t            beat_chk = CHK_MODEL;
  mcei_pkg::out_beat_t beat_irq = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;

  mcei_pkg::out_beat_t pending_irqs [$];
  plan_row_t           plan [$];

  // Shadow of the detector: registers, per-channel level/stamp, ms counter
  logic                          shadow_en = 1'b0;
  logic [mcei_pkg::REG_W-1:0]    shadow_used = '0;
  logic [mcei_pkg::REG_W-1:0]    shadow_rise = '0;
  logic [mcei_pkg::REG_W-1:0]    shadow_fall = '0;
  logic                          chan_level [mcei_pkg::MAX_SLOTS];
  logic [mcei_pkg::STAMP_W-1:0]  chan_stamp [mcei_pkg::MAX_SLOTS];
  logic [mcei_pkg::STAMP_W-1:0]  ms_count = '0;

  multi_channel_edge_interrupt_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  assign as_clk_unused_dummy_guard = 1'b0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register side effects: enable rise restarts time, enable fall wipes all
  // channel state, used-bit toggles clear the level (and the stamp on set).
  function automatic void track_reg_write(mcei_pkg::reg_idx_t idx,
                                          logic [mcei_pkg::REG_W-1:0] v);
    case (idx)
      mcei_pkg::REG_ENABLE: begin
        if (!shadow_en && v[0]) begin
          ms_count = '0;
        end else if (shadow_en && !v[0]) begin
          foreach (chan_level[c]) begin
            chan_level[c] = 1'b0;
            chan_stamp[c] = '0;
          end
        end
        shadow_en = v[0];
      end
      mcei_pkg::REG_USED: begin
        for (int c = 0; c < mcei_pkg::MAX_SLOTS; c++) begin
          if (shadow_used[c] != v[c]) begin
            chan_level[c] = 1'b0;
            if (v[c]) chan_stamp[c] = '0;
          end
        end
        shadow_used = v;
      end
      mcei_pkg::REG_RISE: shadow_rise = v;
      default:            shadow_fall = v;
    endcase
  endfunction

  // One beat through the detector: tick advances time; a sample on an
  // enabled, in-use channel that differs from the stored level is an edge.
  function automatic void detect_edge(input mcei_pkg::in_beat_t b, output logic fire,
                                      output mcei_pkg::out_beat_t r);
    logic [mcei_pkg::CH_W-1:0] ch;
    ch   = b.channel;
    fire = 1'b0;
    r    = '0;
    if (b.mode == mcei_pkg::MODE_TICK) begin
      ms_count = ms_count + 1'b1;
    end else if (shadow_en && ch < NCH && shadow_used[ch] &&
                 chan_level[ch] != b.level) begin
      chan_level[ch]  = b.level;
      chan_stamp[ch]  = ms_count;
      fire            = b.level ? shadow_rise[ch] : shadow_fall[ch];
      r.irq_channel   = ch;
      r.edge_rising   = b.level;
      r.stamp_ms      = ms_count;
    end
  endfunction

  // Single monitor at the rising edge: check the outgoing interrupt first,
  // then account for register writes and accepted beats, so queue order never
  // depends on process scheduling.
  always @(posedge clk) begin : monitor
    mcei_pkg::out_beat_t want;
    mcei_pkg::out_beat_t got;
    logic                fire;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_irqs.size() == 0) begin
          $error("interrupt beat with none pending: irq_channel %0d edge_rising %0d stamp_ms %0d",
                 out_data.irq_channel, out_data.edge_rising, out_data.stamp_ms);
          err_cnt++;
        end else begin
          want = pending_irqs.pop_front();
          if (out_data.irq_channel !== want.irq_channel) begin
            $error("irq_channel: expected %0d, got %0d", want.irq_channel,
                   out_data.irq_channel);
            err_cnt++;
          end
          if (out_data.edge_rising !== want.edge_rising) begin
            $error("edge_rising: expected %0d, got %0d", want.edge_rising,
                   out_data.edge_rising);
            err_cnt++;
          end
          if (out_data.stamp_ms !== want.stamp_ms) begin
            $error("stamp_ms: expected %0d, got %0d", want.stamp_ms, out_data.stamp_ms);
            err_cnt++;
          end
        end
      end
      if (psel && penable && pwrite && pready)
        track_reg_write(mcei_pkg::reg_idx_t'(paddr[3:2]), pwdata);
      if (in_valid && in_ready) begin
        detect_edge(in_data, fire, got);
        case (beat_chk)
          CHK_IRQ:   pending_irqs.push_back(beat_irq);
          CHK_QUIET: ;
          default:   if (fire) pending_irqs.push_back(got);
        endcase
      end
    end
  end

  // Receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("multi_channel_edge_interrupt_core verification failed");
    $finish;
  end

  function automatic plan_row_t reg_row(mcei_pkg::reg_idx_t idx,
                                        logic [mcei_pkg::REG_W-1:0] v);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = v;
    return r;
  endfunction

  function automatic plan_row_t beat_row(logic mode, logic [mcei_pkg::CH_W-1:0] ch,
                                         logic lvl, row_chk_t chk,
                                         logic [mcei_pkg::CH_W-1:0] irq_ch,
                                         logic irq_rise,
                                         logic [mcei_pkg::STAMP_W-1:0] irq_ms);
    plan_row_t r;
    r                 = '0;
    r.kind            = ROW_BEAT;
    r.beat.mode       = mode;
    r.beat.channel    = ch;
    r.beat.level      = lvl;
    r.chk             = chk;
    r.irq.irq_channel = irq_ch;
    r.irq.edge_rising = irq_rise;
    r.irq.stamp_ms    = irq_ms;
    return r;
  endfunction

  function automatic logic [mcei_pkg::REG_W-1:0] pick_mask();
    case ($urandom_range(7))
      0:       return '0;
      1, 2:    return '1;
      default: return $urandom | $urandom;  // dense, so most channels see edges
    endcase
  endfunction

  // All driver tasks enter and leave just after a falling edge.
  task automatic send_beat(mcei_pkg::in_beat_t b, row_chk_t chk,
                           mcei_pkg::out_beat_t irq);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    beat_chk <= chk;
    beat_irq <= irq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, let every expected interrupt drain, then cover items still
  // in the pipe that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_irqs.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  // The bus then idles before the next transfer.
  task automatic reg_write(mcei_pkg::reg_idx_t idx, logic [mcei_pkg::REG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    mcei_pkg::in_beat_t b;
    foreach (chan_level[c]) begin
      chan_level[c] = 1'b0;
      chan_stamp[c] = '0;
    end

    // Directed walk. Stamps are easy to follow: time restarts at enable.
    plan = {
      // after reset: block disabled, sample ignored; tick still counts
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd0,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_TICK,   5'd0,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      reg_row(mcei_pkg::REG_USED, 32'hFFFF_FFFF),
      reg_row(mcei_pkg::REG_RISE, 32'hFFFF_FFFF),
      reg_row(mcei_pkg::REG_FALL, 32'hFFFF_FFFF),
      reg_row(mcei_pkg::REG_ENABLE, 32'h1),                    // time back to 0
      // lowest and highest channel, both directions
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd0,  1'b1, CHK_IRQ,   5'd0,  1'b1, 32'd0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd31, 1'b1, CHK_IRQ,   5'd31, 1'b1, 32'd0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd31, 1'b1, CHK_QUIET, '0, 1'b0, '0), // no change
      beat_row(mcei_pkg::MODE_TICK,   5'd0,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_TICK,   5'd0,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd31, 1'b0, CHK_IRQ,   5'd31, 1'b0, 32'd2),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd0,  1'b0, CHK_IRQ,   5'd0,  1'b0, 32'd2),
      // masked rising edge still updates level and stamp
      reg_row(mcei_pkg::REG_RISE, 32'h0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b0, CHK_IRQ,   5'd5,  1'b0, 32'd2),
      reg_row(mcei_pkg::REG_FALL, 32'h0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      // unregister channel 5: level cleared, samples ignored
      reg_row(mcei_pkg::REG_USED, 32'hFFFF_FFDF),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      reg_row(mcei_pkg::REG_RISE, 32'hFFFF_FFFF),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      // register it again: level starts at 0, so a high sample is an edge
      reg_row(mcei_pkg::REG_USED, 32'hFFFF_FFFF),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_IRQ,   5'd5,  1'b1, 32'd2),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      // tick ignores channel and level fields
      beat_row(mcei_pkg::MODE_TICK,   5'd31, 1'b1, CHK_QUIET, '0, 1'b0, '0),
      // disable wipes channel state; time keeps running while off
      reg_row(mcei_pkg::REG_ENABLE, 32'h0),
      beat_row(mcei_pkg::MODE_TICK,   5'd0,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd7,  1'b1, CHK_QUIET, '0, 1'b0, '0),
      reg_row(mcei_pkg::REG_ENABLE, 32'h1),
      reg_row(mcei_pkg::REG_FALL, 32'hFFFF_FFFF),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b0, CHK_QUIET, '0, 1'b0, '0), // level wiped
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd5,  1'b1, CHK_IRQ,   5'd5,  1'b1, 32'd0),
      beat_row(mcei_pkg::MODE_TICK,   5'd0,  1'b0, CHK_QUIET, '0, 1'b0, '0),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd9,  1'b1, CHK_MODEL, '0, 1'b0, '0),
      // enable rewritten while on (upper bits set): no restart of time
      reg_row(mcei_pkg::REG_ENABLE, 32'hFFFF_FFFF),
      beat_row(mcei_pkg::MODE_SAMPLE, 5'd9,  1'b0, CHK_MODEL, '0, 1'b0, '0)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].beat, plan[i].chk, plan[i].irq);
      end
    end

    // Random part: per phase, several register settings, each followed by a
    // burst of mixed samples and ticks across all channels.
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = TX_IDLE[ph];
      rx_stall_pct = RX_STALL[ph];
      for (int seg = 0; seg < SEGS; seg++) begin
        settle();
        if ($urandom_range(3) == 0) reg_write(mcei_pkg::REG_ENABLE, '0);  // wipe + restart
        reg_write(mcei_pkg::REG_USED, pick_mask());
        reg_write(mcei_pkg::REG_RISE, pick_mask());
        reg_write(mcei_pkg::REG_FALL, pick_mask());
        // bit 0 is the enable; other bits are junk the block must drop
        reg_write(mcei_pkg::REG_ENABLE, ($urandom & 32'hFFFF_FFFE) |
                                        32'($urandom_range(7) != 0));
        for (int n = 0; n < SEG_BEATS; n++) begin
          b.mode    = ($urandom_range(99) < 15) ? mcei_pkg::MODE_TICK
                                                : mcei_pkg::MODE_SAMPLE;
          b.channel = mcei_pkg::CH_W'($urandom_range(31));
          b.level   = 1'($urandom_range(1));
          send_beat(b, CHK_MODEL, '0);
        end
      end
    end

    settle();
    if (err_cnt == 0)
      $display("multi_channel_edge_interrupt_core verification clean");
    else
      $display("multi_channel_edge_interrupt_core verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mcei_pkg.sv
hw/rtl/mcei_ram.sv
hw/rtl/mcei_regs.sv
hw/rtl/mcei_detect.sv
hw/rtl/multi_channel_edge_interrupt_core.sv
hw/rtl/mcei_checker.sv
sim/multi_channel_edge_interrupt_core_tb.sv
